[rtl/text_console_writer_defines.svh]
// Assertion macros for the text console writer checker.
// Needs clk and rst in scope where the macros are used.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw: next-cycle check failed");

`endif

[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; used by the screen RAM, the top level and the checker.
package tcw_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 20;
  localparam int CELL_COUNT   = ROWS * COLUMNS;
  localparam int SCROLL_CELLS = (ROWS - 2) * COLUMNS;
  localparam int ADDR_W       = $clog2(CELL_COUNT);
  localparam int ROW_W        = 5;
  localparam int COL_W        = 7;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_PROMPT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] PROMPT_CODE  = 8'h3E;
  localparam logic [7:0] CURSOR_CODE  = 8'h5F;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  typedef logic [15:0] cell_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_column;
  } cmd_t;

  typedef struct packed {
    logic [15:0]      cell_value;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_column;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

[rtl/tcw_screen_ram.sv]
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for depth and port types.
module tcw_screen_ram (
  input  logic            clk,
  input  tcw_pkg::ram_wr_t wr,
  input  tcw_pkg::ram_rd_t rd,
  output tcw_pkg::cell_t   rd_data
);
  import tcw_pkg::*;

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[rtl/text_console_writer.sv]
// Top level of the text console writer: command sequencer around the screen RAM.
// Depends on tcw_pkg and tcw_screen_ram.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one item at a time: put a
//   character (newline code wraps the line), draw the ">_" prompt at the
//   cursor, or read one cell. rsp channel (rsp_valid / rsp_stall / rsp) returns
//   exactly one item per command: the cell read (zero for other ops and for
//   out-of-range reads), the cursor after it. cfg_we / cfg_data set the text colour.
// Sequencer states per command, from accept to response loaded:
//   plain character, read, unused op : idle, response
//   prompt                           : idle, prompt, response
//   line end without scroll          : idle, newline, row clear, response
//   line end with scroll             : idle, newline, scroll, row clear, response
// Reset: the sequencer sweeps all CELL_COUNT cells, writing blanks in colour
// 0x07 with the prompt at the origin; cmd_stall is high for the whole sweep.
// Config writes are taken during the sweep.
// Stall: the response sits in an output register; while rsp_stall holds it,
// the next command is still accepted and worked on, and waits for the
// register in the response state.
module text_console_writer (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  tcw_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tcw_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_PROMPT  = 3'd2;
  localparam logic [2:0] ST_NEWLINE = 3'd3;
  localparam logic [2:0] ST_SCROLL  = 3'd4;
  localparam logic [2:0] ST_CLRROW  = 3'd5;
  localparam logic [2:0] ST_RESP    = 3'd6;

  // Linear cell address: row * COLUMNS + column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  logic [2:0]        state;
  logic [ADDR_W-1:0] cnt;          // sweep / scroll / row-clear position
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic              bottom;       // cursor has hit the last row once
  logic [7:0]        text_color;
  logic              rd_hit;       // pending item is an in-range read

  ram_wr_t           wr;
  ram_rd_t           rd;
  cell_t             rd_data;

  logic              accept;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W:0]   prompt_next;
  logic              prompt_in;
  logic              read_ok;
  logic [ROW_W:0]    row_plus;
  logic [7:0]        init_char;

  tcw_screen_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign cmd_stall   = (state != ST_IDLE);
  assign accept      = cmd_valid && !cmd_stall;
  assign cur_addr    = cell_addr(row, col);
  assign prompt_next = {1'b0, cur_addr} + (ADDR_W+1)'(1);
  // '_' past the last cell of the screen is dropped
  assign prompt_in   = prompt_next < (ADDR_W+1)'(CELL_COUNT);
  assign read_ok     = (cmd.read_row < ROW_W'(ROWS)) && (cmd.read_column < COL_W'(COLUMNS));
  assign row_plus    = {1'b0, row} + (ROW_W+1)'(1);

  always_comb begin
    if (cnt == ADDR_W'(0)) begin
      init_char = PROMPT_CODE;
    end else if (cnt == ADDR_W'(1)) begin
      init_char = CURSOR_CODE;
    end else begin
      init_char = BLANK_CODE;
    end
  end

  // RAM port steering per sequencer state.
  always_comb begin
    wr = '0;
    rd = '0;
    unique case (state)
      ST_INIT: begin
        // reset image always uses the reset colour, not the live register
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = {RESET_COLOR, init_char};
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd.op)
            OP_PUT: begin
              wr.en   = (cmd.char_code != NEWLINE_CODE);
              wr.addr = cur_addr;
              wr.data = {text_color, cmd.char_code};
            end
            OP_PROMPT: begin
              wr.en   = 1'b1;
              wr.addr = cur_addr;
              wr.data = {text_color, PROMPT_CODE};
            end
            OP_READ: begin
              rd.en   = read_ok;
              rd.addr = cell_addr(cmd.read_row, cmd.read_column);
            end
            default: ;
          endcase
        end
      end
      ST_PROMPT: begin
        wr.en   = prompt_in;
        wr.addr = prompt_next[ADDR_W-1:0];
        wr.data = {text_color, CURSOR_CODE};
      end
      ST_SCROLL: begin
        // read one row ahead, write back what was read last cycle;
        // the write address always trails the read address by COLUMNS+1
        rd.en   = (cnt < ADDR_W'(SCROLL_CELLS));
        rd.addr = cnt + ADDR_W'(COLUMNS);
        wr.en   = (cnt != ADDR_W'(0));
        wr.addr = cnt - ADDR_W'(1);
        wr.data = rd_data;
      end
      ST_CLRROW: begin
        wr.en   = 1'b1;
        wr.addr = cell_addr(row, cnt[COL_W-1:0]);
        wr.data = {text_color, BLANK_CODE};
      end
      default: ;
    endcase
  end

  // Sequencer and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      bottom     <= 1'b0;
      text_color <= RESET_COLOR;
      rd_hit     <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_data;
      end
      // a response state reloads the register itself
      if (rsp_valid && !rsp_stall && (state != ST_RESP)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_hit <= (cmd.op == OP_READ) && read_ok;
            case (cmd.op)
              OP_PUT: begin
                if (cmd.char_code == NEWLINE_CODE) begin
                  col   <= '0;
                  state <= ST_NEWLINE;
                end else if (col == COL_W'(COLUMNS - 1)) begin
                  col   <= '0;
                  state <= ST_NEWLINE;
                end else begin
                  col   <= col + COL_W'(1);
                  state <= ST_RESP;
                end
              end
              OP_PROMPT: state <= ST_PROMPT;
              default:   state <= ST_RESP;
            endcase
          end
        end
        ST_PROMPT: begin
          state <= ST_RESP;
        end
        ST_NEWLINE: begin
          cnt <= '0;
          if (row_plus >= (ROW_W+1)'(ROWS - 1)) begin
            if (bottom) begin
              row   <= ROW_W'(ROWS - 2);
              state <= ST_SCROLL;
            end else begin
              bottom <= 1'b1;
              row    <= ROW_W'(ROWS - 1);
              state  <= ST_CLRROW;
            end
          end else begin
            row   <= row_plus[ROW_W-1:0];
            state <= ST_CLRROW;
          end
        end
        ST_SCROLL: begin
          if (cnt == ADDR_W'(SCROLL_CELLS)) begin
            cnt   <= '0;
            state <= ST_CLRROW;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_CLRROW: begin
          if (cnt == ADDR_W'(COLUMNS - 1)) begin
            cnt   <= '0;
            state <= ST_RESP;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Response payload; RAM read data holds since no read is issued in ST_RESP.
  always_ff @(posedge clk) begin
    if ((state == ST_RESP) && (!rsp_valid || !rsp_stall)) begin
      rsp.cell_value    <= rd_hit ? rd_data : 16'h0000;
      rsp.cursor_row    <= row;
      rsp.cursor_column <= col;
    end
  end

endmodule

[rtl/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_defines.svh.
`include "text_console_writer_defines.svh"

module tcw_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input tcw_pkg::rsp_t rsp
);
  import tcw_pkg::*;

  logic cursor_ok;

  assign cursor_ok = (rsp.cursor_row < ROW_W'(ROWS)) &&
                     (rsp.cursor_column < COL_W'(COLUMNS));

  // cursor reported is always on screen
  `TCW_ASSERT_IMP(a_rsp_cursor_range, rsp_valid, cursor_ok)

  // held response stays put
  `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // screen sweep after reset keeps commands out
  `TCW_ASSERT_IMP(a_stall_after_reset, $past(rst), cmd_stall)

  // one command in flight
  `TCW_ASSERT_NEXT(a_one_in_flight, cmd_valid && !cmd_stall, cmd_stall)

  // a new response only comes out of a busy cycle
  `TCW_ASSERT_IMP(a_rsp_from_work, $rose(rsp_valid), $past(cmd_stall))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
